// ----- design/first_fit_page_allocator_macros.svh -----
// Assertion helpers for the page allocator checkers.
`ifndef FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH
`define FIRST_FIT_PAGE_ALLOCATOR_MACROS_SVH

// Generic form: explicit clock and active-low reset.
`define FFPA_ASSERT_CLK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Default clock and reset of this block.
`define FFPA_ASSERT(label, prop, msg) `FFPA_ASSERT_CLK(label, clk_i, rst_ni, prop, msg)

`endif

// ----- design/ffpa_pkg.sv -----
package ffpa_pkg;

  localparam int PAGE_W      = 20;
  localparam int LEN_W       = 9;
  localparam int MASK_W      = 4;
  localparam int STATUS_W    = 2;
  localparam int CFG_ARENAS  = 4;
  localparam int ARENA_IDX_W = 2;
  localparam int APB_AW      = 5;
  localparam int APB_DW      = 32;
  localparam int REG_IDX_W   = 3;

  typedef enum logic {
    ACT_ALLOC = 1'b0,
    ACT_FREE  = 1'b1
  } action_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK           = 2'd0,
    STAT_NO_SPACE     = 2'd1,
    STAT_NOT_IN_ARENA = 2'd2,
    STAT_DOUBLE_FREE  = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_ALLOC_SEL,
    S_ALLOC_SCAN,
    S_ALLOC_MARK,
    S_FREE_SEL,
    S_FREE_SCAN,
    S_DONE
  } state_e;

endpackage

// ----- design/ffpa_req_if.sv -----
interface ffpa_req_if;
  import ffpa_pkg::*;

  logic              valid;
  logic              ready;
  logic              action;
  logic [LEN_W-1:0]  run_length;
  logic [MASK_W-1:0] arena_mask;
  logic [PAGE_W-1:0] free_page;

  modport source (output valid, action, run_length, arena_mask, free_page, input ready);
  modport sink   (input valid, action, run_length, arena_mask, free_page, output ready);
endinterface

// ----- design/ffpa_rsp_if.sv -----
interface ffpa_rsp_if;
  import ffpa_pkg::*;

  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [PAGE_W-1:0]   page_number;

  modport source (output valid, status, page_number, input ready);
  modport sink   (input valid, status, page_number, output ready);
endinterface

// ----- design/ffpa_map_ram.sv -----
module ffpa_map_ram #(
  parameter int AW = 10
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic          wdata_i,
  input  logic          re_i,
  input  logic [AW-1:0] raddr_i,
  output logic          rdata_o
);

  localparam int DEPTH = 1 << AW;

  logic mem_q [DEPTH];
  logic rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- design/first_fit_page_allocator.sv -----
// Channel  Dir  Role    Word
// req_i    in   sink    action, run_length, arena_mask, free_page
// rsp_o    out  source  status, page_number
// apb      in   slave   arena base / page count registers, write at access phase
//
// After reset a clearing pass zeroes every page map entry, one bit a cycle; no request
// is taken meanwhile.
// Allocate: try the arenas in arena_mask in order and scan each map for a free run (one map
// read a cycle through the single read port), then mark run_length pages as used.
// Free: find the arena that holds the page, then clear its pages, flagging any already free.
// One request at a time; a held response does not block taking the next request.
module first_fit_page_allocator #(
  parameter int ARENA_COUNT     = 4,
  parameter int PAGES_PER_ARENA = 256
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  ffpa_req_if.sink                     req_i,
  ffpa_rsp_if.source                   rsp_o,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [ffpa_pkg::APB_AW-1:0]  paddr,
  input  logic [ffpa_pkg::APB_DW-1:0]  pwdata,
  output logic [ffpa_pkg::APB_DW-1:0]  prdata,
  output logic                         pready
);
  import ffpa_pkg::*;

  localparam int NUM_ARENAS  = (ARENA_COUNT < CFG_ARENAS) ? ARENA_COUNT : CFG_ARENAS;
  localparam int CNT_W       = $clog2(PAGES_PER_ARENA + 1);
  localparam int NW          = (CNT_W > LEN_W) ? CNT_W : LEN_W;
  localparam int OFF_W       = (PAGES_PER_ARENA > 1) ? $clog2(PAGES_PER_ARENA) : 1;
  localparam int MAP_ARENA_W = (ARENA_COUNT > 1) ? $clog2(ARENA_COUNT) : 1;
  localparam int MAP_AW      = MAP_ARENA_W + OFF_W;

  // configuration registers
  logic [PAGE_W-1:0] base_q [CFG_ARENAS];
  logic [LEN_W-1:0]  cnt_q  [CFG_ARENAS];
  logic [REG_IDX_W-1:0] reg_idx;

  assign reg_idx = paddr[APB_AW-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < CFG_ARENAS; i++) begin
        base_q[i] <= '0;
        cnt_q[i]  <= '0;
      end
    end else if (psel && penable && pwrite) begin
      if (reg_idx[0]) begin
        cnt_q[reg_idx[REG_IDX_W-1:1]] <= pwdata[LEN_W-1:0];
      end else begin
        base_q[reg_idx[REG_IDX_W-1:1]] <= pwdata[PAGE_W-1:0];
      end
    end
  end

  always_comb begin
    if (reg_idx[0]) begin
      prdata = APB_DW'(cnt_q[reg_idx[REG_IDX_W-1:1]]);
    end else begin
      prdata = APB_DW'(base_q[reg_idx[REG_IDX_W-1:1]]);
    end
  end

  // sequencer state
  state_e                 state_q, state_d;
  logic [ARENA_IDX_W-1:0] aidx_q, aidx_d;
  logic [LEN_W-1:0]       len_q, len_d;
  logic [MASK_W-1:0]      mask_q, mask_d;
  logic [PAGE_W-1:0]      page_q, page_d;
  logic [NW-1:0]          rd_idx_q, rd_idx_d;
  logic [NW-1:0]          wr_idx_q, wr_idx_d;
  logic [NW-1:0]          end_idx_q, end_idx_d;
  logic [NW-1:0]          run_q, run_d;
  logic [LEN_W-1:0]       left_q, left_d;
  logic                   dval_q, dval_d;
  status_e                res_status_q, res_status_d;
  logic [PAGE_W-1:0]      res_page_q, res_page_d;
  logic                   out_valid_q, out_valid_d;
  status_e                out_status_q, out_status_d;
  logic [PAGE_W-1:0]      out_page_q, out_page_d;
  logic [MAP_AW-1:0]      clr_q, clr_d;

  // map port
  logic              ram_we, ram_wdata, ram_re, ram_rdata;
  logic [MAP_AW-1:0] ram_waddr, ram_raddr;

  ffpa_map_ram #(
    .AW (MAP_AW)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  logic [NW-1:0]          n_cur;
  logic [NW-1:0]          len_n;
  logic [NW-1:0]          run_inc;
  logic [NW-1:0]          start;
  logic [PAGE_W:0]        diff;
  logic                   last;
  logic                   issue;
  logic [MAP_ARENA_W-1:0] arena_sel;

  always_comb begin
    // page count clamped to the per-arena map size
    if (NW'(cnt_q[aidx_q]) > NW'(PAGES_PER_ARENA)) begin
      n_cur = NW'(PAGES_PER_ARENA);
    end else begin
      n_cur = NW'(cnt_q[aidx_q]);
    end
    len_n     = NW'(len_q);
    run_inc   = run_q + NW'(1);
    start     = wr_idx_q + NW'(1) - len_n;
    diff      = {1'b0, page_q} - {1'b0, base_q[aidx_q]};
    last      = (aidx_q == ARENA_IDX_W'(NUM_ARENAS - 1));
    arena_sel = MAP_ARENA_W'(aidx_q);
    issue     = 1'b0;

    state_d      = state_q;
    aidx_d       = aidx_q;
    len_d        = len_q;
    mask_d       = mask_q;
    page_d       = page_q;
    rd_idx_d     = rd_idx_q;
    wr_idx_d     = wr_idx_q;
    end_idx_d    = end_idx_q;
    run_d        = run_q;
    left_d       = left_q;
    dval_d       = 1'b0;
    res_status_d = res_status_q;
    res_page_d   = res_page_q;
    clr_d        = clr_q;

    ram_we    = 1'b0;
    ram_wdata = 1'b0;
    ram_waddr = {arena_sel, wr_idx_q[OFF_W-1:0]};
    ram_re    = 1'b0;
    ram_raddr = {arena_sel, rd_idx_q[OFF_W-1:0]};

    out_valid_d  = out_valid_q && !rsp_o.ready;
    out_status_d = out_status_q;
    out_page_d   = out_page_q;

    unique case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        clr_d     = clr_q + MAP_AW'(1);
        if (clr_q == '1) begin
          state_d = S_IDLE;
        end
      end

      S_IDLE: begin
        if (req_i.valid) begin
          len_d      = req_i.run_length;
          mask_d     = req_i.arena_mask;
          page_d     = req_i.free_page;
          aidx_d     = '0;
          res_page_d = '0;
          state_d    = (req_i.action == ACT_ALLOC) ? S_ALLOC_SEL : S_FREE_SEL;
        end
      end

      S_ALLOC_SEL: begin
        if (mask_q[aidx_q] && (len_q != '0) && (len_n <= n_cur)) begin
          rd_idx_d = '0;
          wr_idx_d = '0;
          run_d    = '0;
          state_d  = S_ALLOC_SCAN;
        end else if (last) begin
          res_status_d = STAT_NO_SPACE;
          state_d      = S_DONE;
        end else begin
          aidx_d = aidx_q + ARENA_IDX_W'(1);
        end
      end

      S_ALLOC_SCAN: begin
        // reads run one page ahead of the check; wr_idx tracks the page checked
        issue = (rd_idx_q < n_cur);
        if (issue) begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + NW'(1);
        end
        dval_d = issue;
        if (dval_q) begin
          wr_idx_d = wr_idx_q + NW'(1);
          if (ram_rdata) begin
            run_d = '0;
          end else begin
            run_d = run_inc;
            if (run_inc == len_n) begin
              res_page_d = base_q[aidx_q] + PAGE_W'(start);
              end_idx_d  = wr_idx_q;
              wr_idx_d   = start;
              dval_d     = 1'b0;
              state_d    = S_ALLOC_MARK;
            end
          end
        end else if (!issue) begin
          if (last) begin
            res_status_d = STAT_NO_SPACE;
            state_d      = S_DONE;
          end else begin
            aidx_d  = aidx_q + ARENA_IDX_W'(1);
            state_d = S_ALLOC_SEL;
          end
        end
      end

      S_ALLOC_MARK: begin
        ram_we    = 1'b1;
        ram_wdata = 1'b1;
        wr_idx_d  = wr_idx_q + NW'(1);
        if (wr_idx_q == end_idx_q) begin
          res_status_d = STAT_OK;
          state_d      = S_DONE;
        end
      end

      S_FREE_SEL: begin
        // lowest arena whose range holds the page owns it
        if ((n_cur != '0) && !diff[PAGE_W] && (diff[PAGE_W-1:0] < PAGE_W'(n_cur))) begin
          rd_idx_d     = NW'(diff[PAGE_W-1:0]);
          wr_idx_d     = NW'(diff[PAGE_W-1:0]);
          left_d       = len_q;
          res_status_d = STAT_OK;
          state_d      = S_FREE_SCAN;
        end else if (last) begin
          res_status_d = STAT_NOT_IN_ARENA;
          state_d      = S_DONE;
        end else begin
          aidx_d = aidx_q + ARENA_IDX_W'(1);
        end
      end

      S_FREE_SCAN: begin
        issue = (left_q != '0) && (rd_idx_q < n_cur);
        if (issue) begin
          ram_re   = 1'b1;
          rd_idx_d = rd_idx_q + NW'(1);
          left_d   = left_q - LEN_W'(1);
        end
        dval_d = issue;
        if (dval_q) begin
          if (!ram_rdata) begin
            res_status_d = STAT_DOUBLE_FREE;
          end
          ram_we   = 1'b1;
          wr_idx_d = wr_idx_q + NW'(1);
        end else if (!issue) begin
          state_d = S_DONE;
        end
      end

      S_DONE: begin
        if (!out_valid_q || rsp_o.ready) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_page_d   = res_page_q;
          state_d      = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      aidx_q      <= '0;
      dval_q      <= 1'b0;
      out_valid_q <= 1'b0;
      clr_q       <= '0;
    end else begin
      state_q     <= state_d;
      aidx_q      <= aidx_d;
      dval_q      <= dval_d;
      out_valid_q <= out_valid_d;
      clr_q       <= clr_d;
    end
  end

  always_ff @(posedge clk_i) begin
    len_q        <= len_d;
    mask_q       <= mask_d;
    page_q       <= page_d;
    rd_idx_q     <= rd_idx_d;
    wr_idx_q     <= wr_idx_d;
    end_idx_q    <= end_idx_d;
    run_q        <= run_d;
    left_q       <= left_d;
    res_status_q <= res_status_d;
    res_page_q   <= res_page_d;
    out_status_q <= out_status_d;
    out_page_q   <= out_page_d;
  end

  assign req_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = out_valid_q;
  assign rsp_o.status      = out_status_q;
  assign rsp_o.page_number = out_page_q;

endmodule

// ----- design/ffpa_checker.sv -----
module ffpa_checker (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           req_valid_i,
  input  logic                           req_ready_i,
  input  logic                           rsp_valid_i,
  input  logic                           rsp_ready_i,
  input  logic [ffpa_pkg::STATUS_W-1:0]  rsp_status_i,
  input  logic [ffpa_pkg::PAGE_W-1:0]    rsp_page_i
);
  import ffpa_pkg::*;
  `include "first_fit_page_allocator_macros.svh"

  // a stalled response word holds
  `FFPA_ASSERT(a_rsp_hold, rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_status_i) && $stable(rsp_page_i), "response changed while stalled")

  // only a successful allocation carries a page number
  `FFPA_ASSERT(a_page_zero, rsp_valid_i && (rsp_status_i != STAT_OK) |-> rsp_page_i == '0, "page number on failed request")

  // a taken request makes the request side go busy while the search runs
  `FFPA_ASSERT(a_busy_after_accept, req_valid_i && req_ready_i |=> !req_ready_i, "request taken while busy")

endmodule

bind first_fit_page_allocator ffpa_checker u_ffpa_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .req_valid_i  (req_i.valid),
  .req_ready_i  (req_i.ready),
  .rsp_valid_i  (rsp_o.valid),
  .rsp_ready_i  (rsp_o.ready),
  .rsp_status_i (rsp_o.status),
  .rsp_page_i   (rsp_o.page_number)
);
